>>> design/plpc_pkg.sv
// ----------------------------------------------------------------------------
// plpc_pkg
// shared constants for the prbs lfsr period checker: status codes, defaults
// ----------------------------------------------------------------------------
package plpc_pkg;

  // default lfsr width
  localparam int LFSR_WIDTH_DEF = 32;

  // fixed widths of the stream fields
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 32;

  // result item packing, padded to whole bytes
  localparam int OUT_FIELDS_W = VALUE_W + COUNT_W + STATUS_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int IN_DATA_W    = 8;

  // feedback mask after reset
  localparam logic [CFG_W-1:0] FEEDBACK_RESET = 32'd96;

  // check status codes
  localparam logic [STATUS_W-1:0] ST_RUN   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PASS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EARLY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOREP = 3'd4;

endpackage

>>> design/prbs_lfsr_period_checker_top.sv
// ----------------------------------------------------------------------------
// prbs_lfsr_period_checker_top
// fibonacci lfsr prbs generator with a maximal-length period check
// ----------------------------------------------------------------------------
// result: an accepted input item's result item is registered on m_tdata in the next cycle
// throughput: 1 item per cycle while m_tready is high; the single registered lfsr/count update sets it
// a waiting result holds s_tready low; the next item is taken as it leaves
// reset (rst, synchronous): lfsr 1, count 0, status running, mask 96, no result
// ----------------------------------------------------------------------------
module prbs_lfsr_period_checker_top
  import plpc_pkg::*;
#(
  parameter int WIDTH = LFSR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: feedback mask
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] value, [63:32] step_count,
                                           // [66:64] status, [67] done_res,
                                           // [71:68] zero
);

  localparam int CW = (WIDTH < CFG_W) ? WIDTH : CFG_W;
  localparam int VW = (WIDTH < VALUE_W) ? WIDTH : VALUE_W;
  localparam int NW = (WIDTH < COUNT_W) ? WIDTH : COUNT_W;
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  // all ones from bit 0 up to the top set bit
  function automatic logic [WIDTH-1:0] smear(input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] p;
    p = m;
    for (int s = 1; s < WIDTH; s = s * 2) begin
      p = p | (p >> s);
    end
    return p;
  endfunction

  // state
  logic [WIDTH-1:0]    mask;
  logic [WIDTH-1:0]    period;
  logic [WIDTH-1:0]    lfsr;
  logic [WIDTH-1:0]    cnt;
  logic [STATUS_W-1:0] st;
  logic                fin;

  logic [WIDTH-1:0]    mask_next;
  logic [WIDTH-1:0]    mask_rst;
  logic [WIDTH-1:0]    lfsr_next;
  logic [WIDTH-1:0]    cnt_next;
  logic [STATUS_W-1:0] st_next;
  logic                fin_next;

  // state after an optional restart
  logic [WIDTH-1:0]    cur_lfsr;
  logic [WIDTH-1:0]    cur_cnt;
  logic [STATUS_W-1:0] cur_st;
  logic                cur_fin;
  logic                restart;

  logic [WIDTH-1:0]    adv_lfsr;
  logic [WIDTH-1:0]    adv_cnt;
  logic                fb;

  logic                in_acc;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign restart  = s_tdata[0];

  // configuration mask and its period
  assign mask_rst  = WIDTH'(FEEDBACK_RESET);
  assign mask_next = cfg_wen ? WIDTH'(cfg_wdata[CW-1:0]) : mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask   <= mask_rst;
      period <= smear(mask_rst);
    end else begin
      mask   <= mask_next;
      period <= smear(mask_next);
    end
  end

  // restart applies before the tick
  always_comb begin
    cur_lfsr = restart ? ONE : lfsr;
    cur_cnt  = restart ? '0 : cnt;
    cur_st   = restart ? ST_RUN : st;
    cur_fin  = restart ? 1'b0 : fin;
  end

  // one lfsr advance
  assign fb       = ^(cur_lfsr & mask);
  assign adv_lfsr = ({cur_lfsr[WIDTH-2:0], fb}) & period;
  assign adv_cnt  = cur_cnt + ONE;

  // tick decision
  always_comb begin
    lfsr_next = cur_lfsr;
    cnt_next  = cur_cnt;
    st_next   = cur_st;
    fin_next  = cur_fin;
    if (!cur_fin) begin
      priority if (cur_cnt >= period) begin
        fin_next = 1'b1;
        if (cur_lfsr == '0)       st_next = ST_ZERO;
        else if (cur_lfsr != ONE) st_next = ST_NOREP;
        else                      st_next = ST_PASS;
      end else if (cur_lfsr == '0) begin
        st_next  = ST_ZERO;
        fin_next = 1'b1;
      end else if (cur_cnt != '0 && cur_lfsr == ONE) begin
        st_next  = ST_EARLY;
        fin_next = 1'b1;
      end else begin
        lfsr_next = adv_lfsr;
        cnt_next  = adv_cnt;
        if (adv_cnt >= period) begin
          fin_next = 1'b1;
          if (adv_lfsr == '0)       st_next = ST_ZERO;
          else if (adv_lfsr != ONE) st_next = ST_NOREP;
          else                      st_next = ST_PASS;
        end
      end
    end
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= ONE;
      cnt  <= '0;
      st   <= ST_RUN;
      fin  <= 1'b0;
    end else if (in_acc) begin
      lfsr <= lfsr_next;
      cnt  <= cnt_next;
      st   <= st_next;
      fin  <= fin_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_tdata <= OUT_DATA_W'({fin_next, st_next, COUNT_W'(cnt_next[NW-1:0]),
                              VALUE_W'(cur_lfsr[VW-1:0])});
    end
  end

  // checks
  a_fin_status : assert property (@(posedge clk) disable iff (rst)
    fin == (st != ST_RUN))
    else $error("finished flag and status disagree");

  a_acc_result : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> m_tvalid)
    else $error("accepted item gave no result");

  a_hold_done : assert property (@(posedge clk) disable iff (rst)
    (in_acc && fin && !restart) |=> ($stable(lfsr) && $stable(cnt) && $stable(st)))
    else $error("state changed after finish");

endmodule
